>>> hw/rtl/sobel_edge_threshold_assert.svh
// Assertion helpers shared by the Sobel block. Every module that uses them
// has a clock named aclk and a synchronous active-low reset named aresetn.
`ifndef SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOBEL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOBEL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sobel_pkg.sv
package sobel_pkg;

    // Field widths of the result word.
    localparam int COL_W = 11;
    localparam int ROW_W = 16;

    // Configuration register widths and indexes.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_REG_W = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam int THRESH_REG_W = 11;
    localparam int LIM_SQ_W = 23;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [THRESH_REG_W-1:0] THRESH_RESET = 11'd50;
    localparam logic [LIM_SQ_W-1:0] LIM_SQ_RESET = 23'd2601;

    // Queue between the window front end and the gradient back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;
    localparam int Q_CW = 3;

    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 32;

    // Coordinates and frame marker that travel with each window.
    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
    } meta_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic [Q_CW-1:0] level;
        logic            nonempty;
    } q_stat_t;

endpackage

>>> hw/rtl/sobel_fifo.sv
`include "sobel_edge_threshold_assert.svh"

module sobel_fifo #(
    parameter int WIDTH = 100
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       head_data,
    output sobel_pkg::q_stat_t     q_stat
);

    logic [WIDTH-1:0]                 entry_reg [sobel_pkg::Q_DEPTH];
    logic [sobel_pkg::Q_AW-1:0]       wr_ptr_reg;
    logic [sobel_pkg::Q_AW-1:0]       rd_ptr_reg;
    logic [sobel_pkg::Q_CW-1:0]       count_reg;
    logic [sobel_pkg::Q_CW-1:0]       count_next;

    assign count_next = count_reg + sobel_pkg::Q_CW'(push) - sobel_pkg::Q_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data       = entry_reg[rd_ptr_reg];
    assign q_stat.level    = count_reg;
    assign q_stat.nonempty = (count_reg != '0);

    `SOBEL_ASSERT_NOW(a_no_overflow, push && !pop, count_reg < sobel_pkg::Q_CW'(sobel_pkg::Q_DEPTH), "queue written while full")
    `SOBEL_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "queue read while empty")
    `SOBEL_ASSERT_NEXT(a_count_track, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue level lost a word")

endmodule

>>> hw/rtl/sobel_front.sv
`include "sobel_edge_threshold_assert.svh"

module sobel_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int QW = $bits(sobel_pkg::meta_t) + 9 * PIXEL_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sobel_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [AW-1:0]                      col_last,
    input  logic [sobel_pkg::ROW_W-1:0]        row_last,
    input  sobel_pkg::q_stat_t                 q_stat,
    output logic                               q_push,
    output logic [QW-1:0]                      q_data
);

    localparam int PB = PIXEL_BITS;

    // Each line memory word holds the pixel one row up in the low half and
    // the pixel two rows up in the high half, at the same column.
    logic [2*PB-1:0]                 line_mem [MAX_WIDTH];
    logic [2*PB-1:0]                 rd_reg;

    logic [AW-1:0]                   col_reg;
    logic [sobel_pkg::ROW_W-1:0]     row_reg;

    logic                            p1_valid_reg;
    logic                            p1_inner_reg;
    logic [AW-1:0]                   p1_x_reg;
    logic [PB-1:0]                   p1_px_reg;
    sobel_pkg::meta_t                p1_meta_reg;

    logic [3*PB-1:0]                 win_c1_reg;
    logic [3*PB-1:0]                 win_c2_reg;
    logic [3*PB-1:0]                 col_new;

    logic                            accept;
    logic                            col_end;
    logic                            row_end;
    logic [PB+7:0]                   px_ext;
    logic [PB-1:0]                   px;
    logic [AW-1:0]                   col_m1;
    logic [AW+10:0]                  col_m1_ext;
    logic [sobel_pkg::Q_CW:0]        in_flight;
    sobel_pkg::meta_t                meta_now;

    // Room is counted for the word still in the read stage.
    assign in_flight = {1'b0, q_stat.level} + (sobel_pkg::Q_CW + 1)'(p1_valid_reg);
    assign s_tready  = aresetn && (in_flight < (sobel_pkg::Q_CW + 1)'(sobel_pkg::Q_DEPTH));
    assign accept    = s_tvalid && s_tready;

    assign px_ext = {{PB{1'b0}}, s_tdata};
    assign px     = px_ext[PB-1:0];

    assign col_end = (col_reg >= col_last);
    assign row_end = (row_reg >= row_last);

    assign col_m1     = col_reg - 1'b1;
    assign col_m1_ext = {11'd0, col_m1};

    always_comb begin
        meta_now.last   = col_end && row_end;
        meta_now.row    = row_reg - 1'b1;
        meta_now.column = col_m1_ext[sobel_pkg::COL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
            if (accept) begin
                if (col_end) begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg       <= line_mem[col_reg];
            p1_x_reg     <= col_reg;
            p1_px_reg    <= px;
            p1_meta_reg  <= meta_now;
            p1_inner_reg <= (col_reg >= AW'(2)) && (row_reg >= sobel_pkg::ROW_W'(2));
        end
        if (p1_valid_reg) begin
            line_mem[p1_x_reg] <= {rd_reg[PB-1:0], p1_px_reg};
        end
    end

    // New right column: two rows up, one row up, current pixel (top first).
    assign col_new = {p1_px_reg, rd_reg[PB-1:0], rd_reg[2*PB-1:PB]};

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            win_c1_reg <= win_c2_reg;
            win_c2_reg <= col_new;
        end
    end

    assign q_push = p1_valid_reg && p1_inner_reg;
    assign q_data = {p1_meta_reg, col_new, win_c2_reg, win_c1_reg};

    `SOBEL_ASSERT_NEXT(a_frame_wrap, accept && col_end && row_end, (col_reg == '0) && (row_reg == '0), "counters did not wrap at frame end")

endmodule

>>> hw/rtl/sobel_back.sv
`include "sobel_edge_threshold_assert.svh"

module sobel_back #(
    parameter int PIXEL_BITS = 8,
    localparam int QW = $bits(sobel_pkg::meta_t) + 9 * PIXEL_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sobel_pkg::q_stat_t                 q_stat,
    input  logic [QW-1:0]                      q_data,
    output logic                               q_pop,
    input  logic [sobel_pkg::LIM_SQ_W-1:0]     lim_sq,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sobel_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast
);

    localparam int PB    = PIXEL_BITS;
    localparam int SW    = PB + 2;
    localparam int MAG_W = 2 * SW + 1;
    localparam int CMP_W = (MAG_W > sobel_pkg::LIM_SQ_W) ? MAG_W : sobel_pkg::LIM_SQ_W;

    logic [PB-1:0]          pix [9];
    sobel_pkg::meta_t       q_meta;
    logic [SW-1:0]          pos_x, neg_x, pos_y, neg_y;
    logic signed [SW:0]     sx, sy, abs_x_full, abs_y_full;

    logic                   b1_valid_reg;
    logic [SW-1:0]          b1_ax_reg, b1_ay_reg;
    sobel_pkg::meta_t       b1_meta_reg;

    logic                   b2_valid_reg;
    logic [2*SW-1:0]        b2_sqx_reg, b2_sqy_reg;
    sobel_pkg::meta_t       b2_meta_reg;

    logic                   out_valid_reg;
    logic                   out_edge_reg;
    sobel_pkg::meta_t       out_meta_reg;

    logic                   rdy_out, rdy_b2, rdy_b1;
    logic [MAG_W-1:0]       mag2;

    assign rdy_out = !out_valid_reg || m_tready;
    assign rdy_b2  = !b2_valid_reg || rdy_out;
    assign rdy_b1  = !b1_valid_reg || rdy_b2;
    assign q_pop   = q_stat.nonempty && rdy_b1;

    // Window pixel k sits at column k/3, row k%3, with the top row first.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            pix[k] = q_data[k*PB +: PB];
        end
        q_meta = q_data[9*PB +: $bits(sobel_pkg::meta_t)];
    end

    always_comb begin
        pos_x = SW'(pix[6]) + (SW'(pix[7]) << 1) + SW'(pix[8]);
        neg_x = SW'(pix[0]) + (SW'(pix[1]) << 1) + SW'(pix[2]);
        pos_y = SW'(pix[2]) + (SW'(pix[5]) << 1) + SW'(pix[8]);
        neg_y = SW'(pix[0]) + (SW'(pix[3]) << 1) + SW'(pix[6]);
        sx = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
        sy = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
        abs_x_full = sx[SW] ? -sx : sx;
        abs_y_full = sy[SW] ? -sy : sy;
    end

    assign mag2 = {1'b0, b2_sqx_reg} + {1'b0, b2_sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy_b1) begin
                b1_valid_reg <= q_stat.nonempty;
            end
            if (rdy_b2) begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= b2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b1_ax_reg   <= abs_x_full[SW-1:0];
            b1_ay_reg   <= abs_y_full[SW-1:0];
            b1_meta_reg <= q_meta;
        end
        if (rdy_b2 && b1_valid_reg) begin
            b2_sqx_reg  <= b1_ax_reg * b1_ax_reg;
            b2_sqy_reg  <= b1_ay_reg * b1_ay_reg;
            b2_meta_reg <= b1_meta_reg;
        end
        if (rdy_out && b2_valid_reg) begin
            out_edge_reg <= (CMP_W'(mag2) >= CMP_W'(lim_sq));
            out_meta_reg <= b2_meta_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_meta_reg.last;
    // m_tdata from bit 0: column[10:0], row[26:11], edge_res[27], zero fill.
    assign m_tdata  = {4'd0, out_edge_reg, out_meta_reg.row, out_meta_reg.column};

    `SOBEL_ASSERT_NEXT(a_stage_hold, b2_valid_reg && !rdy_out, b2_valid_reg && $stable(b2_sqx_reg) && $stable(b2_meta_reg), "square stage changed while stalled")
    `SOBEL_ASSERT_NOW(a_pop_has_room, q_pop, !b1_valid_reg || rdy_b2, "window taken with no room in first stage")

endmodule

>>> hw/rtl/sobel_edge_threshold.sv
// Sobel 3x3 edge detector for a raster stream of grey pixels. One pixel word
// is accepted per clock for as long as result words are taken: the line
// memory is read once and written once per pixel, and the gradient, squaring
// and threshold stages are pipelined. Pixels on the first and last row and
// column produce no result. Every other pixel yields one result word holding
// its column, its row and the edge decision (squared gradient magnitude at
// least (edge_threshold+1)^2). It passes the read stage, the queue and the
// gradient, square and threshold registers in turn. tlast marks the final
// interior pixel of a frame. A four-word queue separates the window front
// end from the gradient back end, so input keeps flowing through short
// output stalls. s_tready drops once the queue and the read stage together
// hold four words. A register write applies to the next pixel accepted, and
// registers should be changed only while no pixel is in flight. Width values
// outside 3..MAX_WIDTH and heights below 3 are clamped. The line memory needs
// no clearing pass.
module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sobel_pkg::IN_TDATA_W-1:0]   s_tdata,   // pixel[7:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sobel_pkg::OUT_TDATA_W-1:0]  m_tdata,   // column[10:0], row[26:11], edge_res[27]
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [sobel_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(sobel_pkg::meta_t) + 9 * PIXEL_BITS;

    logic [sobel_pkg::WIDTH_REG_W-1:0]   width_reg;
    logic [sobel_pkg::HEIGHT_REG_W-1:0]  height_reg;
    logic [sobel_pkg::THRESH_REG_W-1:0]  thresh_reg;

    logic [AW-1:0]                       col_last;
    logic [sobel_pkg::ROW_W-1:0]         row_last;
    logic [sobel_pkg::LIM_SQ_W-1:0]      lim_sq_reg, lim_sq_next;
    logic [sobel_pkg::WIDTH_REG_W-1:0]   lim;
    logic [2*sobel_pkg::WIDTH_REG_W-1:0] lim_prod;

    logic                                q_push, q_pop;
    logic [QW-1:0]                       q_in_data, q_head_data;
    sobel_pkg::q_stat_t                  q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sobel_pkg::WIDTH_RESET;
            height_reg <= sobel_pkg::HEIGHT_RESET;
            thresh_reg <= sobel_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sobel_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata[sobel_pkg::WIDTH_REG_W-1:0];
                end
                sobel_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata[sobel_pkg::HEIGHT_REG_W-1:0];
                end
                sobel_pkg::REG_EDGE_THRESHOLD: begin
                    thresh_reg <= cfg_wdata[sobel_pkg::THRESH_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamped last column and row feed the counters directly, so a new size
    // holds for the very next pixel. The squared threshold is only needed a
    // few stages later and is kept in a register.
    always_comb begin
        if (width_reg < sobel_pkg::WIDTH_REG_W'(3)) begin
            col_last = AW'(2);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            col_last = AW'(MAX_WIDTH - 1);
        end else begin
            col_last = AW'(width_reg - 1'b1);
        end
        if (height_reg < sobel_pkg::HEIGHT_REG_W'(3)) begin
            row_last = sobel_pkg::ROW_W'(2);
        end else begin
            row_last = height_reg - 1'b1;
        end
        lim         = {1'b0, thresh_reg} + 1'b1;
        lim_prod    = {{sobel_pkg::WIDTH_REG_W{1'b0}}, lim} * {{sobel_pkg::WIDTH_REG_W{1'b0}}, lim};
        lim_sq_next = lim_prod[sobel_pkg::LIM_SQ_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_sq_reg <= sobel_pkg::LIM_SQ_RESET;
        end else begin
            lim_sq_reg <= lim_sq_next;
        end
    end

    sobel_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .col_last (col_last),
        .row_last (row_last),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_in_data)
    );

    sobel_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .q_stat    (q_stat)
    );

    sobel_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_data   (q_head_data),
        .q_pop    (q_pop),
        .lim_sq   (lim_sq_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> verif/tb_sobel_edge_threshold.sv
module tb_sobel_edge_threshold;

    localparam int LINE_LEN      = 2048;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PIXELS = 1450;
    localparam int FILL_WIDTH    = 64;

    typedef struct {
        logic [sobel_pkg::COL_W-1:0] column;
        logic [sobel_pkg::ROW_W-1:0] row;
        logic                        is_edge;
        logic                        last;
    } edge_word_t;

    // Tracks the block's registers, line memory, window and counters, and keeps
    // the edge decisions that are still due on the result side.
    class edge_board;
        logic [sobel_pkg::WIDTH_REG_W-1:0]  width_reg;
        logic [sobel_pkg::HEIGHT_REG_W-1:0] height_reg;
        logic [sobel_pkg::THRESH_REG_W-1:0] thresh_reg;
        bit [7:0]                           line_up1 [LINE_LEN];
        bit [7:0]                           line_up2 [LINE_LEN];
        int                                 win [3][3];
        logic [sobel_pkg::COL_W-1:0]        col_cnt;
        logic [sobel_pkg::ROW_W-1:0]        row_cnt;
        edge_word_t                         due_edges [$];
        int                                 mismatches;

        function new();
            width_reg  = sobel_pkg::WIDTH_RESET;
            height_reg = sobel_pkg::HEIGHT_RESET;
            thresh_reg = sobel_pkg::THRESH_RESET;
            col_cnt    = '0;
            row_cnt    = '0;
            mismatches = 0;
            foreach (win[i, j]) win[i][j] = 0;
        endfunction

        function void set_reg(logic [sobel_pkg::CFG_ADDR_W-1:0] idx,
                              logic [sobel_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sobel_pkg::REG_IMAGE_WIDTH:
                    width_reg  = val[sobel_pkg::WIDTH_REG_W-1:0];
                sobel_pkg::REG_IMAGE_HEIGHT:
                    height_reg = val[sobel_pkg::HEIGHT_REG_W-1:0];
                sobel_pkg::REG_EDGE_THRESHOLD:
                    thresh_reg = val[sobel_pkg::THRESH_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_edges.size();
        endfunction

        function bit at_frame_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        function void take_pixel(logic [7:0] px);
            int unsigned     w, h, x, y;
            int              up1, up2, gx, gy, i;
            longint unsigned mag2, lim;
            bit              col_end, row_end;
            edge_word_t      r;
            w = 32'(width_reg);
            if (w < 3) w = 3;
            if (w > LINE_LEN) w = LINE_LEN;
            h = 32'(height_reg);
            if (h < 3) h = 3;
            x = 32'(col_cnt);
            y = 32'(row_cnt);
            up1 = int'(line_up1[x]);
            up2 = int'(line_up2[x]);
            col_end = (x >= w - 1);
            row_end = (y >= h - 1);

            for (i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = up2;
            win[1][2] = up1;
            win[2][2] = int'(px);
            line_up2[x] = 8'(up1);
            line_up1[x] = px;

            if (x >= 2 && y >= 2) begin
                gx = (win[0][2] + 2 * win[1][2] + win[2][2])
                   - (win[0][0] + 2 * win[1][0] + win[2][0]);
                gy = (win[2][0] + 2 * win[2][1] + win[2][2])
                   - (win[0][0] + 2 * win[0][1] + win[0][2]);
                mag2 = longint'(gx * gx) + longint'(gy * gy);
                lim = longint'(thresh_reg) + 1;
                r.column  = sobel_pkg::COL_W'(x - 1);
                r.row     = sobel_pkg::ROW_W'(y - 1);
                r.is_edge = (mag2 >= lim * lim);
                r.last    = col_end && row_end;
                due_edges.push_back(r);
            end

            if (col_end) begin
                col_cnt = '0;
                row_cnt = row_end ? '0 : sobel_pkg::ROW_W'(y + 1);
            end else begin
                col_cnt = sobel_pkg::COL_W'(x + 1);
            end
        endfunction

        function void compare(string what, logic [15:0] expv, logic [15:0] gotv);
            if (gotv !== expv) begin
                $display("%0t: %s expected %0d got %0d", $time, what, expv, gotv);
                mismatches++;
            end
        endfunction

        function void check_word(logic [sobel_pkg::OUT_TDATA_W-1:0] data, logic last);
            edge_word_t e;
            if (due_edges.size() == 0) begin
                $display("%0t: result word %h (last %b) arrived with nothing expected",
                         $time, data, last);
                mismatches++;
                return;
            end
            e = due_edges.pop_front();
            compare("column", 16'(e.column), 16'(data[sobel_pkg::COL_W-1:0]));
            compare("row", e.row, data[sobel_pkg::COL_W+sobel_pkg::ROW_W-1:sobel_pkg::COL_W]);
            compare("edge flag", 16'(e.is_edge), 16'(data[sobel_pkg::COL_W+sobel_pkg::ROW_W]));
            compare("last of frame", 16'(e.last), 16'(last));
            compare("padding", 16'd0,
                    16'(data[sobel_pkg::OUT_TDATA_W-1:sobel_pkg::COL_W+sobel_pkg::ROW_W+1]));
        endfunction
    endclass

    logic                                  aclk      = 1'b0;
    logic                                  aresetn   = 1'b0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [sobel_pkg::IN_TDATA_W-1:0]      s_tdata   = '0;
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [sobel_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                  m_tlast;
    logic                                  cfg_wr_en = 1'b0;
    logic [sobel_pkg::CFG_ADDR_W-1:0]      cfg_addr  = '0;
    logic [sobel_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

    edge_board board = new();
    bit        idle_on = 1'b1;
    int        pixels_sent = 0;

    sobel_edge_threshold u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic push_pixel(input logic [7:0] px);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_pixel(px);
        pixels_sent++;
    endtask

    // Holds input off until every due result is back, then lets the pipeline
    // run dry so a word with no result can not be in flight during a write.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sobel_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [sobel_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    function automatic logic [7:0] next_pixel(int style, int base);
        case (style)
            1:       return 8'(base + int'($urandom_range(0, 15)));
            2:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            3:       return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'(base);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random register values, with random junk above the width and threshold register widths.
    function automatic logic [sobel_pkg::CFG_DATA_W-1:0] reg_value(
            logic [sobel_pkg::CFG_ADDR_W-1:0] idx, int style);
        logic [sobel_pkg::CFG_DATA_W-1:0] v;
        case (idx)
            sobel_pkg::REG_IMAGE_WIDTH: begin
                v = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(13, FILL_WIDTH))
                                                : 16'($urandom_range(3, 12));
                if ($urandom_range(0, 9) == 0) v = 16'($urandom_range(0, 2));
                v[sobel_pkg::CFG_DATA_W-1:sobel_pkg::WIDTH_REG_W] = 4'($urandom_range(0, 15));
            end
            sobel_pkg::REG_IMAGE_HEIGHT: begin
                v = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                : 16'($urandom_range(3, 8));
            end
            default: begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       v = 16'd0;
                        1:       v = 16'd1443;
                        default: v = 16'd2047;
                    endcase
                end else if (style == 1) begin
                    v = 16'($urandom_range(0, 90));
                end else if (style == 2) begin
                    v = 16'($urandom_range(0, 1443));
                end else begin
                    v = 16'($urandom_range(0, 700));
                end
                v[sobel_pkg::CFG_DATA_W-1:sobel_pkg::THRESH_REG_W] = 5'($urandom_range(0, 31));
            end
        endcase
        return v;
    endfunction

    // Sends pixels until the counters wrap to the start of the next frame.
    // A register may be rewritten part way through, once the block is idle;
    // widening is safe here because the wide frame has filled every column
    // that a random width can reach before this is used.
    task automatic send_frame(input int style, input int base, input bit mid_change);
        int                               cut, k;
        logic [sobel_pkg::CFG_ADDR_W-1:0] idx;
        cut = mid_change ? int'($urandom_range(1, 40)) : -1;
        k = 0;
        do begin
            if (k == cut) begin
                settle();
                case ($urandom_range(0, 2))
                    0:       idx = sobel_pkg::REG_IMAGE_WIDTH;
                    1:       idx = sobel_pkg::REG_IMAGE_HEIGHT;
                    default: idx = sobel_pkg::REG_EDGE_THRESHOLD;
                endcase
                write_reg(idx, reg_value(idx, style));
            end
            push_pixel(next_pixel(style, base));
            k++;
        end while (!board.at_frame_start());
    endtask

    // Result side: random stalls ahead of each word while idle_on is set, checked on acceptance.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_on ? int'($urandom_range(0, 5)) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            board.check_word(m_tdata, m_tlast);
        end
    end

    initial begin : stimulus
        int x, y, style, base, start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 5x5 frame at the reset threshold: dark top left block on a white
        // ground gives flat windows, pure horizontal and vertical steps and
        // mixed corners.
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 16'd5);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 16'd5);
        for (y = 0; y < 5; y++)
            for (x = 0; x < 5; x++)
                push_pixel((x >= 3 || y >= 3) ? 8'hFF : 8'h00);

        // Clamped sizes with a vertical step of magnitude exactly 1020,
        // once just over the threshold and once at it.
        settle();
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 16'd1);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 16'd0);
        write_reg(sobel_pkg::REG_EDGE_THRESHOLD, 16'd1019);
        for (y = 0; y < 3; y++)
            for (x = 0; x < 3; x++)
                push_pixel((x == 2) ? 8'hFF : 8'h00);
        settle();
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 16'd2);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 16'd2);
        write_reg(sobel_pkg::REG_EDGE_THRESHOLD, 16'd1020);
        for (y = 0; y < 3; y++)
            for (x = 0; x < 3; x++)
                push_pixel((x == 2) ? 8'hFF : 8'h00);

        // Widest random frame, streamed without gaps.
        settle();
        idle_on = 1'b0;
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 16'(FILL_WIDTH));
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 16'd3);
        write_reg(sobel_pkg::REG_EDGE_THRESHOLD, 16'($urandom_range(200, 700)));
        send_frame(0, 0, 1'b0);

        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            settle();
            idle_on = ($urandom_range(0, 4) != 0);
            style = int'($urandom_range(0, 3));
            base = int'($urandom_range(0, 240));
            write_reg(sobel_pkg::REG_IMAGE_WIDTH,
                      reg_value(sobel_pkg::REG_IMAGE_WIDTH, style));
            write_reg(sobel_pkg::REG_IMAGE_HEIGHT,
                      reg_value(sobel_pkg::REG_IMAGE_HEIGHT, style));
            if ($urandom_range(0, 3) != 0)
                write_reg(sobel_pkg::REG_EDGE_THRESHOLD,
                          reg_value(sobel_pkg::REG_EDGE_THRESHOLD, style));
            send_frame(style, base, $urandom_range(0, 3) == 0);
        end

        settle();
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
